>>> design/tcw_pkg.sv
package tcw_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  localparam int CMD_W       = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int ROW_IN_W    = 6;
  localparam int COL_IN_W    = 7;
  localparam int POS_W       = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CHAR_W-1:0] CHAR_E       = 8'h45;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_code_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEFAULT_ATTR = 1'b0,
    REG_ERROR_ATTR   = 1'b1
  } reg_index_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [CHAR_W-1:0]   ch;
    logic [ATTR_W-1:0]   attr;
    logic                use_cursor;
    logic                bad;
    logic [ROW_IN_W-1:0] row;
    logic [COL_IN_W-1:0] col;
    logic [POS_W-1:0]    idx;
  } cmd_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic              error;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
  } res_item_t;

  typedef struct packed {
    logic [ATTR_W-1:0] default_attr;
    logic [ATTR_W-1:0] error_attr;
  } cfg_regs_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

>>> design/text_console_writer_core.sv
// Text console writer: a ROWS x COLS grid of character/attribute cells with a cursor.
// Requests enter through a queue-style port: an item is taken when push is high and
// full is low. Each request gives exactly one result, presented while empty is low
// and taken when pop is high. Two configuration registers (default and error
// attribute) are written through cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and writes belong to times when no request is in flight.
// A put character or a command with no effect writes its result into the result queue
// as it is taken from the input queue; a read goes through the S_READ_WAIT state and then the result queue.
// Outside scrolls, puts run at one per cycle while results are popped, limited by
// the single cell write port of the screen memory. A put that moves past the last cell
// scrolls the screen: each moved cell is read, then written one row up, and then the
// last row is zeroed. A clear writes a space in the default attribute to every cell.
// During both, new requests collect in the input queue and then hold off on full.
// After reset the screen memory is swept to zero, one cell per cycle, and full stays
// high meanwhile; configuration writes are taken throughout.
// When the receiver stops popping, results wait in a two-entry output queue and the
// engine pauses before starting a request whose result has no slot.
module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [CMD_W-1:0]       command,
  input  logic [CHAR_W-1:0]      character,
  input  logic [ROW_IN_W-1:0]    row,
  input  logic [COL_IN_W-1:0]    col,
  input  logic                   use_cursor,
  input  logic [ATTR_W-1:0]      attr,
  output logic                   empty,
  input  logic                   pop,
  output logic [POS_W-1:0]       position,
  output logic                   error,
  output logic [CHAR_W-1:0]      cell_char,
  output logic [ATTR_W-1:0]      cell_attr,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_regs_t    cfg;
  cmd_item_t    item;
  logic         item_valid;
  logic         cmd_pop;
  back_status_t status;
  res_item_t    res;
  logic         res_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_attr <= DEFAULT_ATTR_RST;
      cfg.error_attr   <= ERROR_ATTR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEFAULT_ATTR: cfg.default_attr <= cfg_data[ATTR_W-1:0];
        REG_ERROR_ATTR:   cfg.error_attr   <= cfg_data[ATTR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tcw_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .character (character),
    .row       (row),
    .col       (col),
    .use_cursor(use_cursor),
    .attr      (attr),
    .status    (status),
    .cmd_pop   (cmd_pop),
    .item      (item),
    .item_valid(item_valid)
  );

  tcw_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .item_valid(item_valid),
    .cmd_pop   (cmd_pop),
    .status    (status),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty     = !res_valid;
  assign position  = res.position;
  assign error     = res.error;
  assign cell_char = res.cell_char;
  assign cell_attr = res.cell_attr;

endmodule

>>> design/tcw_fifo.sv
module tcw_fifo
  import tcw_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/tcw_front.sv
module tcw_front
  import tcw_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [CMD_W-1:0]    command,
  input  logic [CHAR_W-1:0]   character,
  input  logic [ROW_IN_W-1:0] row,
  input  logic [COL_IN_W-1:0] col,
  input  logic                use_cursor,
  input  logic [ATTR_W-1:0]   attr,
  input  back_status_t        status,
  input  logic                cmd_pop,
  output cmd_item_t           item,
  output logic                item_valid
);

  cmd_item_t entry;
  logic      q_full;
  logic      accept;
  logic      row_bad;
  logic      col_bad;

  // Inputs are held off while the back sweeps the screen after reset.
  assign full   = q_full || status.init_busy;
  assign accept = push && !full;

  assign row_bad = ({1'b0, row} >= (ROW_IN_W + 1)'(ROWS));
  assign col_bad = ({1'b0, col} >= (COL_IN_W + 1)'(COLS));

  always_comb begin
    entry.cmd        = command;
    entry.ch         = character;
    entry.attr       = attr;
    entry.use_cursor = use_cursor;
    entry.bad        = !use_cursor && (row_bad || col_bad);
    entry.row        = row;
    entry.col        = col;
    entry.idx        = POS_W'(int'(row) * COLS + int'(col));
  end

  tcw_fifo #(
    .WIDTH($bits(cmd_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept),
    .wr_data(entry),
    .full   (q_full),
    .rd_en  (cmd_pop),
    .rd_data(item),
    .valid  (item_valid)
  );

endmodule

>>> design/tcw_back.sv
module tcw_back
  import tcw_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_regs_t    cfg,
  input  cmd_item_t    item,
  input  logic         item_valid,
  output logic         cmd_pop,
  output back_status_t status,
  output res_item_t    res,
  output logic         res_valid,
  input  logic         res_pop
);

  localparam int TOTAL  = ROWS * COLS;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int CELL_W = ATTR_W + CHAR_W;

  localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(TOTAL - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(TOTAL - COLS);
  localparam logic [ADDR_W-1:0] SCROLL_LAST   = ADDR_W'(TOTAL - COLS - 1);
  localparam logic [ADDR_W-1:0] COL_STEP      = ADDR_W'(COLS);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ_WAIT,
    S_SCROLL_RD,
    S_SCROLL_WR,
    S_ZERO,
    S_CLEAR
  } state_t;

  state_t            state, state_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ADDR_W-1:0] cur_idx, cur_idx_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;

  logic [CELL_W-1:0] cells [TOTAL];
  logic [CELL_W-1:0] rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CELL_W-1:0] mem_wd;
  logic [ADDR_W-1:0] mem_ra;

  res_item_t         res_in;
  logic              res_push;
  logic              res_full;

  logic [ADDR_W-1:0] t_idx;
  logic [ROW_W-1:0]  t_row;
  logic [COL_W-1:0]  t_col;
  logic [ATTR_W-1:0] put_attr;
  logic [ROW_W:0]    row_inc;
  logic              newline;
  logic              step_row;
  logic              wrap;
  logic [ROW_W:0]    n_row;
  logic [COL_W-1:0]  n_col;
  logic [ADDR_W-1:0] n_idx;

  assign status.init_busy = (state == S_INIT);

  // Target cell: the cursor, or the row and column of the request.
  assign t_idx    = item.use_cursor ? cur_idx : item.idx[ADDR_W-1:0];
  assign t_row    = item.use_cursor ? cur_row : item.row[ROW_W-1:0];
  assign t_col    = item.use_cursor ? cur_col : item.col[COL_W-1:0];
  assign put_attr = (item.attr == '0) ? cfg.default_attr : item.attr;

  assign newline  = (item.ch == CHAR_NEWLINE);
  assign row_inc  = {1'b0, t_row} + 1'b1;
  assign step_row = newline || (t_col == COL_W'(COLS - 1));
  assign n_row    = step_row ? row_inc : {1'b0, t_row};
  assign n_col    = step_row ? '0 : t_col + 1'b1;
  assign wrap     = step_row && (row_inc == (ROW_W + 1)'(ROWS));
  assign n_idx    = newline
                  ? ADDR_W'({1'b0, t_idx} - (ADDR_W + 1)'(t_col) + (ADDR_W + 1)'(COLS))
                  : t_idx + 1'b1;

  always_comb begin
    state_next   = state;
    ptr_next     = ptr;
    cur_idx_next = cur_idx;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    mem_we       = 1'b0;
    mem_wa       = ptr;
    mem_wd       = '0;
    mem_ra       = ptr + COL_STEP;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res_in       = '0;
    res_in.position = POS_W'(cur_idx);

    case (state)
      S_INIT: begin
        mem_we = 1'b1;
        if (ptr == LAST_CELL) begin
          ptr_next   = '0;
          state_next = S_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      S_IDLE: begin
        // A request starts only when its result has a slot waiting.
        if (item_valid && !res_full) begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
          case (item.cmd)
            CMD_PUT: begin
              if (item.bad) begin
                mem_we          = 1'b1;
                mem_wa          = LAST_CELL;
                mem_wd          = {cfg.error_attr, CHAR_E};
                res_in.error    = 1'b1;
                res_in.position = item.idx;
              end else begin
                if (!newline) begin
                  mem_we = 1'b1;
                  mem_wa = t_idx;
                  mem_wd = {put_attr, item.ch};
                end
                if (wrap) begin
                  cur_idx_next    = LAST_ROW_BASE;
                  cur_row_next    = ROW_W'(ROWS - 1);
                  cur_col_next    = '0;
                  ptr_next        = '0;
                  state_next      = S_SCROLL_RD;
                  res_in.position = POS_W'(LAST_ROW_BASE);
                end else begin
                  cur_idx_next    = n_idx;
                  cur_row_next    = n_row[ROW_W-1:0];
                  cur_col_next    = n_col;
                  res_in.position = POS_W'(n_idx);
                end
              end
            end
            CMD_CLEAR: begin
              cur_idx_next    = '0;
              cur_row_next    = '0;
              cur_col_next    = '0;
              ptr_next        = '0;
              state_next      = S_CLEAR;
              res_in.position = '0;
            end
            CMD_READ: begin
              if (item.bad) begin
                res_in.error    = 1'b1;
                res_in.position = item.idx;
              end else begin
                res_push   = 1'b0;
                mem_ra     = t_idx;
                state_next = S_READ_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_READ_WAIT: begin
        res_push         = 1'b1;
        res_in.cell_char = rd_data[CHAR_W-1:0];
        res_in.cell_attr = rd_data[CELL_W-1:CHAR_W];
        state_next       = S_IDLE;
      end

      S_SCROLL_RD: begin
        mem_ra     = ptr + COL_STEP;
        state_next = S_SCROLL_WR;
      end

      S_SCROLL_WR: begin
        mem_we = 1'b1;
        mem_wd = rd_data;
        if (ptr == SCROLL_LAST) begin
          ptr_next   = LAST_ROW_BASE;
          state_next = S_ZERO;
        end else begin
          ptr_next   = ptr + 1'b1;
          state_next = S_SCROLL_RD;
        end
      end

      S_ZERO: begin
        mem_we = 1'b1;
        if (ptr == LAST_CELL) begin
          state_next = S_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = {cfg.default_attr, CHAR_SPACE};
        if (ptr == LAST_CELL) begin
          state_next = S_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_wa] <= mem_wd;
    end
    rd_data <= cells[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      ptr     <= '0;
      cur_idx <= '0;
      cur_row <= '0;
      cur_col <= '0;
    end else begin
      state   <= state_next;
      ptr     <= ptr_next;
      cur_idx <= cur_idx_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
    end
  end

  tcw_fifo #(
    .WIDTH($bits(res_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .rd_en  (res_pop),
    .rd_data(res),
    .valid  (res_valid)
  );

endmodule

>>> tb/sv/text_console_writer_core_tb.sv
module text_console_writer_core_tb;
  import tcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS        = ROWS_DEF;
  localparam int COLS        = COLS_DEF;
  localparam int CELLS       = ROWS * COLS;
  localparam int LAST_CELL   = CELLS - 1;
  localparam int HOLD_CYCLES = 400;
  // A scroll or a clear keeps sweeping the screen after its result is out,
  // so the quiet time covers the longest sweep.
  localparam int SETTLE      = 2 * CELLS + 40;
  localparam int MAX_REPORTS = 60;
  localparam int CYCLE_LIMIT = 1_000_000;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [CHAR_W-1:0]   ch;
    logic [ROW_IN_W-1:0] row;
    logic [COL_IN_W-1:0] col;
    logic                use_cursor;
    logic [ATTR_W-1:0]   attr;
  } req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   push       = 1'b0;
  logic                   full;
  logic [CMD_W-1:0]       command    = '0;
  logic [CHAR_W-1:0]      character  = '0;
  logic [ROW_IN_W-1:0]    row        = '0;
  logic [COL_IN_W-1:0]    col        = '0;
  logic                   use_cursor = 1'b0;
  logic [ATTR_W-1:0]      attr       = '0;
  logic                   empty;
  logic                   pop        = 1'b0;
  logic [POS_W-1:0]       position;
  logic                   error;
  logic [CHAR_W-1:0]      cell_char;
  logic [ATTR_W-1:0]      cell_attr;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  text_console_writer_core #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .character  (character),
    .row        (row),
    .col        (col),
    .use_cursor (use_cursor),
    .attr       (attr),
    .empty      (empty),
    .pop        (pop),
    .position   (position),
    .error      (error),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the screen, cursor and attribute registers.
  logic [15:0]       screen_model [CELLS] = '{default: '0};
  int                cursor_model  = 0;
  logic [ATTR_W-1:0] dflt_attr_model = DEFAULT_ATTR_RST;
  logic [ATTR_W-1:0] err_attr_model  = ERROR_ATTR_RST;

  req_t      request_queue[$];
  res_item_t expected_results[$];

  int cycle_count    = 0;
  int mismatch_count = 0;
  int idle_odds      = 0;
  int push_gap       = 0;
  int pop_gap        = 0;
  int hold_requests  = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  // Cursor as seen by the stimulus planner, used to ration scrolls and clears.
  int plan_cursor  = 0;
  int scrolls_left = 0;
  int clears_left  = 0;

  function automatic bit out_of_range(input req_t r);
    return !r.use_cursor && (int'(r.row) >= ROWS || int'(r.col) >= COLS);
  endfunction

  function automatic int addressed_cell(input req_t r);
    return int'(r.row) * COLS + int'(r.col);
  endfunction

  function automatic int next_cursor(input req_t r, input int cur, output bit scroll);
    int target;
    int nxt;
    scroll = 1'b0;
    if (r.command == CMD_CLEAR) return 0;
    if (r.command != CMD_PUT || out_of_range(r)) return cur;
    target = r.use_cursor ? cur : addressed_cell(r);
    nxt = (r.ch == CHAR_NEWLINE) ? (target / COLS + 1) * COLS : target + 1;
    if (nxt >= CELLS) begin
      scroll = 1'b1;
      nxt -= COLS;
    end
    return nxt;
  endfunction

  task automatic predict_request(input req_t r);
    res_item_t res;
    bit scroll;
    int target;
    int nxt;
    logic [ATTR_W-1:0] a;
    res = '0;
    res.position = POS_W'(cursor_model);
    target = r.use_cursor ? cursor_model : addressed_cell(r);
    nxt = next_cursor(r, cursor_model, scroll);
    case (r.command)
      CMD_PUT: begin
        if (out_of_range(r)) begin
          screen_model[LAST_CELL] = {err_attr_model, CHAR_E};
          res.error = 1'b1;
          res.position = POS_W'(addressed_cell(r));
        end else begin
          a = (r.attr == '0) ? dflt_attr_model : r.attr;
          if (r.ch != CHAR_NEWLINE) screen_model[target] = {a, r.ch};
          // The written cell moves up with the rest when the put scrolls.
          if (scroll) begin
            for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = '0;
          end
          res.position = POS_W'(nxt);
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = {dflt_attr_model, CHAR_SPACE};
        res.position = '0;
      end
      CMD_READ: begin
        if (out_of_range(r)) begin
          res.error = 1'b1;
          res.position = POS_W'(addressed_cell(r));
        end else begin
          res.cell_char = screen_model[target][7:0];
          res.cell_attr = screen_model[target][15:8];
        end
      end
      default: ;
    endcase
    cursor_model = nxt;
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_result();
    res_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with no request waiting, position %0d", position));
    end else begin
      want = expected_results.pop_front();
      if (position !== want.position)
        report_mismatch($sformatf("position %0d, expected %0d", position, want.position));
      if (error !== want.error)
        report_mismatch($sformatf("error %0b, expected %0b", error, want.error));
      if (cell_char !== want.cell_char)
        report_mismatch($sformatf("cell_char %02h, expected %02h", cell_char, want.cell_char));
      if (cell_attr !== want.cell_attr)
        report_mismatch($sformatf("cell_attr %02h, expected %02h", cell_attr, want.cell_attr));
    end
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      push     <= 1'b0;
      push_gap <= 0;
    end else begin
      if (push && !full) predict_request(request_queue.pop_front());
      if (push_gap != 0) begin
        push_gap <= push_gap - 1;
        push     <= 1'b0;
      end else if (request_queue.size() == 0) begin
        push <= 1'b0;
      end else if (idle_odds != 0 && !(push && full) &&
                   $urandom_range(0, idle_odds - 1) == 0) begin
        push_gap <= int'($urandom_range(0, 13));
        push     <= 1'b0;
      end else begin
        command    <= request_queue[0].command;
        character  <= request_queue[0].ch;
        row        <= request_queue[0].row;
        col        <= request_queue[0].col;
        use_cursor <= request_queue[0].use_cursor;
        attr       <= request_queue[0].attr;
        push       <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, started on demand from the stimulus sequence.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst) begin
      pop     <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (pop && !empty) check_result();
      if (hold_left != 0) begin
        pop <= 1'b0;
      end else if (pop_gap != 0) begin
        pop_gap <= pop_gap - 1;
        pop     <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        pop_gap <= int'($urandom_range(0, 13));
        pop     <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic req_t make_req(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                    input int r, input int c, input bit cur,
                                    input logic [ATTR_W-1:0] a);
    req_t q;
    q.command    = cmd;
    q.ch         = ch;
    q.row        = ROW_IN_W'(r);
    q.col        = COL_IN_W'(c);
    q.use_cursor = cur;
    q.attr       = a;
    return q;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int pick;
    r.command    = CMD_PUT;
    r.ch         = CHAR_W'($urandom_range(0, 255));
    r.row        = ROW_IN_W'($urandom_range(0, ROWS - 1));
    r.col        = COL_IN_W'($urandom_range(0, COLS - 1));
    r.use_cursor = 1'b0;
    r.attr       = ($urandom_range(0, 4) == 0) ? '0 : ATTR_W'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) r.ch = CHAR_NEWLINE;
    pick = int'($urandom_range(0, 99));
    if (pick < 30) begin
      // Put at an explicit cell: fields as set above.
    end else if (pick < 60) begin
      r.use_cursor = 1'b1;
      r.row = ROW_IN_W'($urandom);
      r.col = COL_IN_W'($urandom);
    end else if (pick < 72) begin
      r.command = CMD_READ;
    end else if (pick < 77) begin
      r.command    = CMD_READ;
      r.use_cursor = 1'b1;
      r.row = ROW_IN_W'($urandom);
      r.col = COL_IN_W'($urandom);
    end else if (pick < 85) begin
      r.command = $urandom_range(0, 1) ? CMD_READ : CMD_PUT;
      if ($urandom_range(0, 1)) begin
        r.row = ROW_IN_W'($urandom_range(ROWS, (1 << ROW_IN_W) - 1));
        r.col = COL_IN_W'($urandom);
      end else begin
        r.row = ROW_IN_W'($urandom);
        r.col = COL_IN_W'($urandom_range(COLS, (1 << COL_IN_W) - 1));
      end
    end else if (pick < 88) begin
      r.command    = CMD_UNUSED;
      r.use_cursor = 1'($urandom_range(0, 1));
      r.row = ROW_IN_W'($urandom);
      r.col = COL_IN_W'($urandom);
    end else if (pick < 91) begin
      r.command    = CMD_CLEAR;
      r.use_cursor = 1'($urandom_range(0, 1));
      r.row = ROW_IN_W'($urandom);
      r.col = COL_IN_W'($urandom);
    end else if (pick < 96) begin
      // Land near the end of the screen so that cursor writes soon scroll.
      r.row = ROW_IN_W'(ROWS - 1);
      r.col = COL_IN_W'($urandom_range(COLS - 4, COLS - 1));
    end else begin
      r.use_cursor = 1'b1;
      r.ch = CHAR_NEWLINE;
    end
    return r;
  endfunction

  // Scrolls and clears are slow, so random requests that would cause one past
  // the budget of the phase become reads with the same fields.
  task automatic queue_request(input req_t r, input bit limited);
    bit scroll;
    int nxt;
    nxt = next_cursor(r, plan_cursor, scroll);
    if (limited && ((scroll && scrolls_left == 0) ||
                    (r.command == CMD_CLEAR && clears_left == 0))) begin
      r.command = CMD_READ;
      nxt = plan_cursor;
    end else begin
      if (scroll) scrolls_left--;
      if (r.command == CMD_CLEAR) clears_left--;
    end
    plan_cursor = nxt;
    request_queue.push_back(r);
  endtask

  task automatic wait_idle();
    while (request_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes the default, then the error attribute; valid stays high throughout.
  task automatic write_attrs(input logic [ATTR_W-1:0] dflt, input logic [ATTR_W-1:0] err);
    cfg_index <= REG_DEFAULT_ATTR;
    cfg_data  <= dflt;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    dflt_attr_model = dflt;
    cfg_index <= REG_ERROR_ATTR;
    cfg_data  <= err;
    do @(posedge clk); while (!cfg_ready);
    err_attr_model = err;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input int count, input int odds, input bit hold);
    scrolls_left = 8;
    clears_left  = 6;
    idle_odds    = odds;
    for (int i = 0; i < count; i++) queue_request(random_request(), 1'b1);
    if (hold) hold_requests++;
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    idle_odds = 8;
    // Directed requests with the attribute registers at their reset values.
    queue_request(make_req(CMD_READ, 8'h00, 0, 0, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_PUT, 8'h41, 0, 0, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_PUT, 8'hFF, 0, 0, 1'b1, 8'hFF), 1'b0);
    queue_request(make_req(CMD_PUT, 8'h00, 0, 0, 1'b1, 8'h01), 1'b0);
    queue_request(make_req(CMD_PUT, CHAR_NEWLINE, 0, 0, 1'b1, 8'h07), 1'b0);
    queue_request(make_req(CMD_READ, 8'h00, 63, 127, 1'b1, 8'h00), 1'b0);
    queue_request(make_req(CMD_READ, 8'h00, 0, 0, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_PUT, 8'h78, ROWS - 1, COLS - 2, 1'b0, 8'h80), 1'b0);
    // Writing the last cell scrolls the screen.
    queue_request(make_req(CMD_PUT, 8'h79, 0, 0, 1'b1, 8'h00), 1'b0);
    queue_request(make_req(CMD_READ, 8'h00, ROWS - 2, COLS - 2, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_READ, 8'h00, ROWS - 2, COLS - 1, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_READ, 8'h00, ROWS - 1, 0, 1'b0, 8'h00), 1'b0);
    // A newline on the last row scrolls without writing a cell.
    queue_request(make_req(CMD_PUT, CHAR_NEWLINE, ROWS - 1, 5, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_PUT, 8'h51, ROWS, 0, 1'b0, 8'h22), 1'b0);
    queue_request(make_req(CMD_PUT, 8'h52, 0, COLS, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_PUT, 8'h53, 63, 127, 1'b0, 8'h33), 1'b0);
    queue_request(make_req(CMD_READ, 8'h00, ROWS - 1, COLS - 1, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_READ, 8'h00, 63, 127, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_READ, 8'h00, 30, 10, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_UNUSED, 8'h55, 63, 127, 1'b0, 8'hAA), 1'b0);
    queue_request(make_req(CMD_UNUSED, 8'hAA, 1, 1, 1'b1, 8'h55), 1'b0);
    queue_request(make_req(CMD_CLEAR, 8'h00, 0, 0, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_READ, 8'h00, 12, 40, 1'b0, 8'h00), 1'b0);
    queue_request(make_req(CMD_PUT, 8'h5A, 63, 127, 1'b1, 8'h00), 1'b0);
    queue_request(make_req(CMD_READ, 8'h00, 0, 0, 1'b0, 8'h00), 1'b0);
    wait_idle();

    write_attrs(8'h00, 8'h00);
    run_random_phase(400, 6, 1'b1);

    write_attrs(8'hFF, 8'hFF);
    run_random_phase(400, 3, 1'b0);

    write_attrs(ATTR_W'($urandom_range(1, 254)), ATTR_W'($urandom_range(1, 254)));
    run_random_phase(600, 12, 1'b1);

    // Closing stretch with both sides running flat out.
    write_attrs(DEFAULT_ATTR_RST, ATTR_W'($urandom_range(0, 255)));
    run_random_phase(500, 0, 1'b0);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/tcw_pkg.sv
design/tcw_fifo.sv
design/tcw_front.sv
design/tcw_back.sv
design/text_console_writer_core.sv
tb/sv/text_console_writer_core_tb.sv
